### rtl/core/pwc_pkg.sv
// Shared constants, types and helper functions of the password record checker.
`timescale 1ns / 1ps

package pwc_pkg;

   // Record layout
   localparam int unsigned REC_LEN    = 44;
   localparam int unsigned CRC_LEN    = 40;
   localparam int unsigned POS_WIDTH  = 6;

   // Reflected CRC-32
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Magic "OAP1", byte 0 first
   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h4F, 8'h41, 8'h50, 8'h31};

   // Reject causes, in check order
   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_CRC      = 3'd1,
      CAUSE_MAGIC    = 3'd2,
      CAUSE_REVISION = 3'd3,
      CAUSE_HEX      = 3'd4
   } cause_type;

   typedef struct packed {
      logic       good;
      logic [3:0] nibble;
   } hex_digit_type;

   // Fold one byte into the running CRC, bit by bit
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'h000000, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Decode one lowercase hex character; a bad character decodes as zero
   function automatic hex_digit_type hex_decode(input logic [7:0] data);
      hex_digit_type d;
      d.good   = 1'b1;
      d.nibble = 4'h0;
      if (data >= 8'h30 && data <= 8'h39) begin
         d.nibble = 4'(data - 8'h30);
      end else if (data >= 8'h61 && data <= 8'h66) begin
         d.nibble = 4'(data - 8'h57);
      end else begin
         d.good = 1'b0;
      end
      return d;
   endfunction

endpackage

### rtl/core/pwc_if.sv
// Handshake interfaces for the record byte channel and the result channel.
`timescale 1ns / 1ps

interface pwc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface pwc_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [2:0]  error_cause;
   logic [31:0] revision;
   logic [63:0] digest_high;
   logic [63:0] digest_low;

   modport source (output valid, output status, output error_cause, output revision,
                   output digest_high, output digest_low, input ready);
   modport sink   (input valid, input status, input error_cause, input revision,
                   input digest_high, input digest_low, output ready);
endinterface

### rtl/core/password_record_checker.sv
// Top level of the password record checker.
//
// Feed a 44-byte stored record on req_bus, one byte per beat; first_byte marks
// byte 0 and drops any partial record. Bytes 0..39 run through a reflected
// CRC-32 whose value must match the little-endian trailer in bytes 40..43.
// The record also needs the magic "OAP1", a nonzero revision in bytes 4..7
// and 32 lowercase hex digest characters in bytes 8..39.
// After byte 43 one beat leaves on rsp_bus with the status, the first failing
// cause (CRC first) and, for a good record, the revision and packed digest.
// Throughput: one byte per cycle while the result register can take a last
// byte. Each byte waits in the input register, then the CRC step and field
// checks update the record state, and byte 43 loads the result beat register.
// Reset empties both registers and restarts the record position at byte 0.
// A stalled receiver holds the result beat; the block still takes bytes until
// the next byte 43 would need the result register, then drops req ready.
`timescale 1ns / 1ps

module password_record_checker (
   input logic         clock,
   input logic         reset,
   pwc_req_if.sink     req_bus,
   pwc_rsp_if.source   rsp_bus
);

   localparam logic [pwc_pkg::POS_WIDTH-1:0] LAST_POS =
      pwc_pkg::POS_WIDTH'(pwc_pkg::REC_LEN - 1);
   localparam logic [pwc_pkg::POS_WIDTH-1:0] CRC_END =
      pwc_pkg::POS_WIDTH'(pwc_pkg::CRC_LEN);

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_first_ff;

   // Record state
   logic [pwc_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rev_ff, rev_in;
   logic [63:0] dig_hi_ff, dig_hi_in;
   logic [63:0] dig_lo_ff, dig_lo_in;
   logic [31:0] trl_ff, trl_in;
   logic        magic_ok_ff, magic_ok_in;
   logic        hex_ok_ff, hex_ok_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   pwc_pkg::cause_type  rsp_cause_ff, cause_in;
   logic [31:0]         rsp_rev_ff;
   logic [63:0]         rsp_hi_ff, rsp_lo_ff;

   // Current view of the state, restarted by first_byte
   logic [pwc_pkg::POS_WIDTH-1:0] pos_cur;
   logic [31:0] crc_cur, rev_cur, trl_cur;
   logic [63:0] dig_hi_cur, dig_lo_cur;
   logic        magic_ok_cur, hex_ok_cur;

   logic [pwc_pkg::POS_WIDTH-1:0] dig_idx;
   logic [31:0] crc_upd, rev_upd, trl_upd;
   logic [63:0] dig_hi_upd, dig_lo_upd;
   logic        magic_ok_upd, hex_ok_upd;
   pwc_pkg::hex_digit_type digit;

   logic s1_last, out_free, s1_go, req_take;

   // Select restarted or running state
   always_comb begin
      if (s1_first_ff) begin
         pos_cur      = '0;
         crc_cur      = pwc_pkg::CRC_INIT;
         rev_cur      = '0;
         dig_hi_cur   = '0;
         dig_lo_cur   = '0;
         trl_cur      = '0;
         magic_ok_cur = 1'b1;
         hex_ok_cur   = 1'b1;
      end else begin
         pos_cur      = pos_ff;
         crc_cur      = crc_ff;
         rev_cur      = rev_ff;
         dig_hi_cur   = dig_hi_ff;
         dig_lo_cur   = dig_lo_ff;
         trl_cur      = trl_ff;
         magic_ok_cur = magic_ok_ff;
         hex_ok_cur   = hex_ok_ff;
      end
   end

   // Handshake: a last byte waits for a free result register
   assign s1_last      = (pos_cur == LAST_POS);
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign s1_go        = s1_valid_ff && (!s1_last || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign req_take     = req_bus.valid && req_bus.ready;

   assign digit   = pwc_pkg::hex_decode(s1_byte_ff);
   assign dig_idx = pos_cur - pwc_pkg::POS_WIDTH'(8);

   // Fold the byte into the record fields
   always_comb begin
      crc_upd      = crc_cur;
      rev_upd      = rev_cur;
      dig_hi_upd   = dig_hi_cur;
      dig_lo_upd   = dig_lo_cur;
      trl_upd      = trl_cur;
      magic_ok_upd = magic_ok_cur;
      hex_ok_upd   = hex_ok_cur;
      if (pos_cur < CRC_END) begin
         crc_upd = pwc_pkg::crc_byte(crc_cur, s1_byte_ff);
      end
      if (pos_cur < pwc_pkg::POS_WIDTH'(4)) begin
         if (s1_byte_ff != pwc_pkg::MAGIC_BYTES[pos_cur[1:0]]) begin
            magic_ok_upd = 1'b0;
         end
      end else if (pos_cur < pwc_pkg::POS_WIDTH'(8)) begin
         rev_upd = rev_cur | ({24'h000000, s1_byte_ff} << {pos_cur[1:0], 3'b000});
      end else if (pos_cur < CRC_END) begin
         if (!digit.good) begin
            hex_ok_upd = 1'b0;
         end
         if (dig_idx[4]) begin
            dig_lo_upd = {dig_lo_cur[59:0], digit.nibble};
         end else begin
            dig_hi_upd = {dig_hi_cur[59:0], digit.nibble};
         end
      end else begin
         trl_upd = trl_cur | ({24'h000000, s1_byte_ff} << {pos_cur[1:0], 3'b000});
      end
   end

   // Pick the first failing cause
   always_comb begin
      if (trl_upd != ~crc_cur) begin
         cause_in = pwc_pkg::CAUSE_CRC;
      end else if (!magic_ok_cur) begin
         cause_in = pwc_pkg::CAUSE_MAGIC;
      end else if (rev_cur == '0) begin
         cause_in = pwc_pkg::CAUSE_REVISION;
      end else if (!hex_ok_cur) begin
         cause_in = pwc_pkg::CAUSE_HEX;
      end else begin
         cause_in = pwc_pkg::CAUSE_NONE;
      end
   end

   // Advance the record, or restart it after the last byte
   always_comb begin
      if (s1_last) begin
         pos_in      = '0;
         crc_in      = pwc_pkg::CRC_INIT;
         rev_in      = '0;
         dig_hi_in   = '0;
         dig_lo_in   = '0;
         trl_in      = '0;
         magic_ok_in = 1'b1;
         hex_ok_in   = 1'b1;
      end else begin
         pos_in      = pos_cur + pwc_pkg::POS_WIDTH'(1);
         crc_in      = crc_upd;
         rev_in      = rev_upd;
         dig_hi_in   = dig_hi_upd;
         dig_lo_in   = dig_lo_upd;
         trl_in      = trl_upd;
         magic_ok_in = magic_ok_upd;
         hex_ok_in   = hex_ok_upd;
      end
   end

   assign s1_valid_in  = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_go && s1_last) ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Hold the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_byte_ff  <= req_bus.data_byte;
         s1_first_ff <= req_bus.first_byte;
      end
   end

   // Update the record state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         crc_ff      <= pwc_pkg::CRC_INIT;
         rev_ff      <= '0;
         dig_hi_ff   <= '0;
         dig_lo_ff   <= '0;
         trl_ff      <= '0;
         magic_ok_ff <= 1'b1;
         hex_ok_ff   <= 1'b1;
      end else if (s1_go) begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         rev_ff      <= rev_in;
         dig_hi_ff   <= dig_hi_in;
         dig_lo_ff   <= dig_lo_in;
         trl_ff      <= trl_in;
         magic_ok_ff <= magic_ok_in;
         hex_ok_ff   <= hex_ok_in;
      end
   end

   // Load the result beat after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_go && s1_last) begin
         rsp_status_ff <= (cause_in != pwc_pkg::CAUSE_NONE);
         rsp_cause_ff  <= cause_in;
         rsp_rev_ff    <= (cause_in == pwc_pkg::CAUSE_NONE) ? rev_cur : 32'h0;
         rsp_hi_ff     <= (cause_in == pwc_pkg::CAUSE_NONE) ? dig_hi_cur : 64'h0;
         rsp_lo_ff     <= (cause_in == pwc_pkg::CAUSE_NONE) ? dig_lo_cur : 64'h0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.error_cause = rsp_cause_ff;
   assign rsp_bus.revision    = rsp_rev_ff;
   assign rsp_bus.digest_high = rsp_hi_ff;
   assign rsp_bus.digest_low  = rsp_lo_ff;

endmodule

### rtl/core/pwc_checker.sv
// Port-level assertions for the password record checker, bound to the top level.
`timescale 1ns / 1ps

module pwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [2:0]  rsp_error_cause,
   input logic [31:0] rsp_revision,
   input logic [63:0] rsp_digest_high,
   input logic [63:0] rsp_digest_low
);

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // A stalled result beat holds its status, cause and revision
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_error_cause) && $stable(rsp_revision))
      else $error("stalled result beat changed");

   // Status flags exactly the records that carry a cause
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == (rsp_error_cause != pwc_pkg::CAUSE_NONE)))
      else $error("status disagrees with error cause");

   // A rejected record shows no fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_revision == 32'h0 &&
         rsp_digest_high == 64'h0 && rsp_digest_low == 64'h0)
      else $error("rejected record leaks fields");

   // A loaded record has a nonzero revision and a cause in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status || rsp_revision != 32'h0) &&
         rsp_error_cause <= pwc_pkg::CAUSE_HEX)
      else $error("bad loaded record or cause out of range");

endmodule

bind password_record_checker pwc_checker u_pwc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_error_cause (rsp_bus.error_cause),
   .rsp_revision    (rsp_bus.revision),
   .rsp_digest_high (rsp_bus.digest_high),
   .rsp_digest_low  (rsp_bus.digest_low)
);
